/* rtl/strict_priority_pause_queue_assert.svh */
// Assertion macros shared by the egress queue RTL.
// Every macro samples on the rising edge of clk and is disabled while rst is high.
`ifndef STRICT_PRIORITY_PAUSE_QUEUE_ASSERT_SVH
`define STRICT_PRIORITY_PAUSE_QUEUE_ASSERT_SVH

// The condition holds at every edge outside reset.
`define SPQ_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// The consequence holds in the cycle after the antecedent.
`define SPQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/spq_pkg.sv */
// Shared constants, codes and types for the strict priority pause queue.
// No dependencies; the top level and spq_class_fifo import it, spq_if takes widths from it.
package spq_pkg;

  localparam int NUM_CLASS  = 3;
  localparam int FIFO_DEPTH = 64;
  localparam int MAX_LEN    = 9216;
  localparam int TAG_BITS   = 16;

  localparam int OP_W     = 2;
  localparam int CLASS_W  = 2;
  localparam int LEN_W    = 14;
  localparam int TIME_W   = 16;
  localparam int EVENT_W  = 3;
  localparam int TOTAL_W  = 21;
  localparam int STATE_W  = 2;

  localparam int PTR_W   = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CNT_W   = $clog2(FIFO_DEPTH + 1);
  localparam int BYTES_W = $clog2(FIFO_DEPTH * MAX_LEN + 1);

  typedef logic [PTR_W-1:0]    ptr_t;
  typedef logic [CNT_W-1:0]    cnt_t;
  typedef logic [BYTES_W-1:0]  bytes_t;
  typedef logic [CLASS_W-1:0]  class_t;
  typedef logic [LEN_W-1:0]    len_t;
  typedef logic [TAG_BITS-1:0] tag_t;

  localparam class_t CLASS_LOW  = 2'd0;
  localparam class_t CLASS_MID  = 2'd1;
  localparam class_t CLASS_HIGH = 2'd2;
  localparam class_t CLASS_NONE = 2'd3;

  typedef enum logic [OP_W-1:0] {
    OP_ENQUEUE = 2'd0,
    OP_PAUSE   = 2'd1,
    OP_DONE    = 2'd2
  } op_e;

  typedef enum logic [EVENT_W-1:0] {
    EV_ENQUEUED = 3'd0,
    EV_DROPPED  = 3'd1,
    EV_PAUSE    = 3'd2,
    EV_DEPARTED = 3'd3,
    EV_STARTED  = 3'd4,
    EV_SPURIOUS = 3'd5
  } event_e;

  typedef enum logic [STATE_W-1:0] {
    ST_READY      = 2'd0,
    ST_PAUSE_RCVD = 2'd1,
    ST_PAUSED     = 2'd2
  } send_state_t;

  typedef struct packed {
    tag_t tag;
    len_t len;
  } desc_t;

  typedef struct packed {
    logic  push;
    logic  pop;
    desc_t desc;
  } fifo_ctl_t;

  typedef struct packed {
    cnt_t  count;
    desc_t head;
    desc_t second;
  } fifo_sts_t;

  typedef struct packed {
    event_e             event_kind;
    class_t             out_class;
    tag_t               out_tag;
    len_t               out_len;
    logic [TOTAL_W-1:0] total_bytes;
    send_state_t        send_state;
    logic               last;
  } result_t;

  function automatic ptr_t ptr_inc(input ptr_t p);
    ptr_inc = (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

endpackage

/* rtl/spq_if.sv */
// Valid/ready channel interfaces for the command and event sides of the queue.
// Depends on spq_pkg for field widths.
interface spq_cmd_if;
  logic                          valid;
  logic                          ready;
  logic [spq_pkg::OP_W-1:0]      operation;
  logic [spq_pkg::CLASS_W-1:0]   pkt_class;
  logic [spq_pkg::LEN_W-1:0]     pkt_len;
  logic [spq_pkg::TAG_BITS-1:0]  pkt_tag;
  logic [spq_pkg::TIME_W-1:0]    pause_time;

  modport source (output valid, operation, pkt_class, pkt_len, pkt_tag, pause_time,
                  input ready);
  modport sink (input valid, operation, pkt_class, pkt_len, pkt_tag, pause_time,
                output ready);
endinterface

interface spq_evt_if;
  logic                          valid;
  logic                          ready;
  logic [spq_pkg::EVENT_W-1:0]   event_kind;
  logic [spq_pkg::CLASS_W-1:0]   out_class;
  logic [spq_pkg::TAG_BITS-1:0]  out_tag;
  logic [spq_pkg::LEN_W-1:0]     out_len;
  logic [spq_pkg::TOTAL_W-1:0]   total_bytes;
  logic [spq_pkg::STATE_W-1:0]   send_state;
  logic                          last;

  modport source (output valid, event_kind, out_class, out_tag, out_len, total_bytes,
                  send_state, last, input ready);
  modport sink (input valid, event_kind, out_class, out_tag, out_len, total_bytes,
                send_state, last, output ready);
endinterface

/* rtl/strict_priority_pause_queue.sv */
// Strict priority egress queue with link pause: top level.
// Depends on spq_pkg, spq_if (channels), spq_class_fifo and the assertion header.
//
//   channel | role   | payload
//   --------+--------+---------------------------------------------------------
//   cmd     | sink   | operation, pkt_class, pkt_len, pkt_tag, pause_time
//   evt     | source | event_kind, out_class, out_tag, out_len, total_bytes,
//           |        | send_state, last
//
// Each command is handled in the cycle it is accepted; its events (one or two, none
// for an unknown operation) land in a two-slot event buffer and leave one per cycle
// while evt is ready, the first one valid in the cycle after the command. A command
// is taken when the buffer is empty or its last event is leaving, so one-event
// commands go one per cycle with evt ready; a start makes cmd wait out both events.
// Synchronous reset empties all class FIFOs and the event buffer; no clearing pass.
// An evt stall holds the buffer and stalls cmd while any event is still waiting.
module strict_priority_pause_queue (
  input  logic       clk,
  input  logic       rst,
  spq_cmd_if.sink    cmd,
  spq_evt_if.source  evt
);
  import spq_pkg::*;
  `include "strict_priority_pause_queue_assert.svh"

  // Queue state
  bytes_t      class_bytes [NUM_CLASS];
  bytes_t      class_bytes_next [NUM_CLASS];
  send_state_t pstate, pstate_next;
  class_t      serving, serving_next;
  logic        in_flight, in_flight_next;

  fifo_ctl_t   fctl [NUM_CLASS];
  fifo_sts_t   fsts [NUM_CLASS];

  // Event buffer
  result_t     slot0, slot1, res_a, res_b;
  logic [1:0]  ocnt, nres;

  logic        cmd_acc, evt_pop, op_known, serv_busy;
  cnt_t        serv_cnt;
  desc_t       serv_head;
  class_t      enq_class;
  len_t        enq_len;
  op_e         op;

  for (genvar c = 0; c < NUM_CLASS; c++) begin : g_class
    spq_class_fifo u_fifo (
      .clk (clk),
      .rst (rst),
      .ctl (fctl[c]),
      .sts (fsts[c])
    );
  end

  assign op       = op_e'(cmd.operation);
  assign op_known = (op == OP_ENQUEUE) || (op == OP_PAUSE) || (op == OP_DONE);
  assign cmd_acc  = cmd.valid && cmd.ready;
  assign evt_pop  = evt.valid && evt.ready;

  // Class code three maps to high; overlong packets saturate.
  assign enq_class = (cmd.pkt_class == CLASS_NONE) ? CLASS_HIGH : cmd.pkt_class;
  assign enq_len   = (cmd.pkt_len > LEN_W'(MAX_LEN)) ? LEN_W'(MAX_LEN) : cmd.pkt_len;

  // Look up the class currently on the wire.
  always_comb begin
    serv_cnt  = '0;
    serv_head = '0;
    for (int c = 0; c < NUM_CLASS; c++) begin
      if (serving == CLASS_W'(c)) begin
        serv_cnt  = fsts[c].count;
        serv_head = fsts[c].head;
      end
    end
  end

  assign serv_busy = in_flight && (serving != CLASS_NONE) && (serv_cnt != '0);

  // Pause state machine: next state.
  always_comb begin
    pstate_next = pstate;
    if (cmd_acc) begin
      unique case (op)
        OP_PAUSE: begin
          if (cmd.pause_time == '0) begin
            pstate_next = ST_READY;
          end else if (pstate == ST_READY) begin
            pstate_next = in_flight ? ST_PAUSE_RCVD : ST_PAUSED;
          end
        end
        OP_DONE: begin
          if (pstate == ST_PAUSE_RCVD) begin
            pstate_next = ST_PAUSED;
          end
        end
        default: pstate_next = pstate;
      endcase
    end
  end

  // Per-command work: FIFO updates, byte counts, events, and the start decision.
  always_comb begin
    cnt_t               cnt_after [NUM_CLASS];
    logic               start;
    class_t             start_class;
    desc_t              start_desc;
    logic [TOTAL_W-1:0] total;

    for (int c = 0; c < NUM_CLASS; c++) begin
      fctl[c].push        = 1'b0;
      fctl[c].pop         = 1'b0;
      fctl[c].desc.tag    = cmd.pkt_tag;
      fctl[c].desc.len    = enq_len;
      class_bytes_next[c] = class_bytes[c];
    end
    in_flight_next = in_flight;
    serving_next   = serving;
    res_a          = '0;
    res_b          = '0;
    res_a.event_kind = EV_PAUSE;
    res_b.event_kind = EV_STARTED;
    start       = 1'b0;
    start_class = CLASS_NONE;
    start_desc  = '0;
    nres        = 2'd0;

    if (cmd_acc && op_known) begin
      unique case (op)
        OP_ENQUEUE: begin
          res_a.out_class = enq_class;
          res_a.out_tag   = cmd.pkt_tag;
          res_a.out_len   = enq_len;
          for (int c = 0; c < NUM_CLASS; c++) begin
            if (enq_class == CLASS_W'(c)) begin
              if (fsts[c].count == CNT_W'(FIFO_DEPTH)) begin
                res_a.event_kind = EV_DROPPED;
              end else begin
                res_a.event_kind    = EV_ENQUEUED;
                fctl[c].push        = 1'b1;
                class_bytes_next[c] = class_bytes[c] + BYTES_W'(enq_len);
              end
            end
          end
        end
        OP_PAUSE: begin
          res_a.event_kind = EV_PAUSE;
        end
        OP_DONE: begin
          if (serv_busy) begin
            res_a.event_kind = EV_DEPARTED;
            res_a.out_class  = serving;
            res_a.out_tag    = serv_head.tag;
            res_a.out_len    = serv_head.len;
            for (int c = 0; c < NUM_CLASS; c++) begin
              if (serving == CLASS_W'(c)) begin
                fctl[c].pop         = 1'b1;
                class_bytes_next[c] = (class_bytes[c] >= BYTES_W'(serv_head.len)) ?
                                      class_bytes[c] - BYTES_W'(serv_head.len) : '0;
              end
            end
          end else begin
            res_a.event_kind = EV_SPURIOUS;
          end
          in_flight_next = 1'b0;
          serving_next   = CLASS_NONE;
        end
        default: res_a.event_kind = EV_PAUSE;
      endcase

      // Fill counts after this command, then pick the highest non-empty class.
      for (int c = 0; c < NUM_CLASS; c++) begin
        cnt_after[c] = fsts[c].count;
        if (fctl[c].push) cnt_after[c] = fsts[c].count + 1'b1;
        if (fctl[c].pop)  cnt_after[c] = fsts[c].count - 1'b1;
      end
      if (pstate_next == ST_READY && !in_flight_next) begin
        for (int c = 0; c < NUM_CLASS; c++) begin
          if (cnt_after[c] != '0) begin
            start       = 1'b1;
            start_class = CLASS_W'(c);
            // Popped class: the entry behind the old head; empty class: bypass.
            if (fctl[c].pop) begin
              start_desc = fsts[c].second;
            end else if (fsts[c].count == '0) begin
              start_desc = fctl[c].desc;
            end else begin
              start_desc = fsts[c].head;
            end
          end
        end
        serving_next = start_class;
        if (start) begin
          in_flight_next = 1'b1;
        end
      end
      nres = start ? 2'd2 : 2'd1;
    end else begin
      for (int c = 0; c < NUM_CLASS; c++) begin
        cnt_after[c] = fsts[c].count;
      end
    end

    total = '0;
    for (int c = 0; c < NUM_CLASS; c++) begin
      total = total + TOTAL_W'(class_bytes_next[c]);
    end

    res_a.total_bytes = total;
    res_a.send_state  = pstate_next;
    res_a.last        = !start;
    res_b.out_class   = start_class;
    res_b.out_tag     = start_desc.tag;
    res_b.out_len     = start_desc.len;
    res_b.total_bytes = total;
    res_b.send_state  = pstate_next;
    res_b.last        = 1'b1;
  end

  // Control state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      pstate    <= ST_READY;
      serving   <= CLASS_NONE;
      in_flight <= 1'b0;
      for (int c = 0; c < NUM_CLASS; c++) begin
        class_bytes[c] <= '0;
      end
    end else begin
      pstate    <= pstate_next;
      serving   <= serving_next;
      in_flight <= in_flight_next;
      for (int c = 0; c < NUM_CLASS; c++) begin
        class_bytes[c] <= class_bytes_next[c];
      end
    end
  end

  // Event buffer: load both slots on a command, else advance on a pop.
  assign cmd.ready = (ocnt == 2'd0) || (ocnt == 2'd1 && evt.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      ocnt <= 2'd0;
    end else if (cmd_acc) begin
      ocnt <= nres;
    end else if (evt_pop) begin
      ocnt <= ocnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_acc) begin
      slot0 <= res_a;
      slot1 <= res_b;
    end else if (evt_pop) begin
      slot0 <= slot1;
    end
  end

  assign evt.valid       = (ocnt != 2'd0);
  assign evt.event_kind  = slot0.event_kind;
  assign evt.out_class   = slot0.out_class;
  assign evt.out_tag     = slot0.out_tag;
  assign evt.out_len     = slot0.out_len;
  assign evt.total_bytes = slot0.total_bytes;
  assign evt.send_state  = slot0.send_state;
  assign evt.last        = slot0.last;

  // Paused only with the wire idle; pause-received only with a packet on it.
  `SPQ_ASSERT_ALWAYS(a_paused_idle, !(pstate == ST_PAUSED && in_flight), "paused in flight")
  `SPQ_ASSERT_ALWAYS(a_rcvd_busy, !(pstate == ST_PAUSE_RCVD && !in_flight), "pause rcvd idle")
  `SPQ_ASSERT_ALWAYS(a_serving_nonempty, !in_flight || serv_busy, "in-flight packet missing")
  `SPQ_ASSERT_NEXT(a_item_answers, cmd_acc && op_known, evt.valid, "command gave no event")

endmodule

/* rtl/spq_class_fifo.sv */
// One class descriptor FIFO: memory, head/tail pointers and fill count.
// Depends on spq_pkg. Presents the head and the entry behind it, both registered.
module spq_class_fifo (
  input  logic               clk,
  input  logic               rst,
  input  spq_pkg::fifo_ctl_t ctl,
  output spq_pkg::fifo_sts_t sts
);
  import spq_pkg::*;

  desc_t mem [FIFO_DEPTH];
  ptr_t  head_ptr, head_ptr_next, tail_ptr;
  ptr_t  rd_addr0, rd_addr1;
  cnt_t  count;
  desc_t head_q, second_q;

  assign head_ptr_next = ctl.pop ? ptr_inc(head_ptr) : head_ptr;
  assign rd_addr0      = head_ptr_next;
  assign rd_addr1      = ptr_inc(head_ptr_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      head_ptr <= '0;
      tail_ptr <= '0;
      count    <= '0;
    end else begin
      head_ptr <= head_ptr_next;
      if (ctl.push) begin
        tail_ptr <= ptr_inc(tail_ptr);
      end
      case ({ctl.push, ctl.pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // Write-first reads: a descriptor written this cycle is forwarded.
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem[tail_ptr] <= ctl.desc;
    end
    head_q   <= (ctl.push && tail_ptr == rd_addr0) ? ctl.desc : mem[rd_addr0];
    second_q <= (ctl.push && tail_ptr == rd_addr1) ? ctl.desc : mem[rd_addr1];
  end

  assign sts.count  = count;
  assign sts.head   = head_q;
  assign sts.second = second_q;

endmodule

/* tb/spq_event_checker.sv */
// Event checker for the strict priority pause queue testbench.
// Watches the cmd and evt channels, predicts the events of every command and compares
// them in order. Depends on spq_pkg and the channel interfaces of spq_if.
module spq_event_checker (
  input  logic clk,
  input  logic rst,
  spq_cmd_if   cmd,
  spq_evt_if   evt,
  output int   fail_count,
  output int   pending_events,
  output int   events_checked,
  output int   drops_seen
);
  import spq_pkg::*;

  // Predicted port state: descriptor rings, occupancy, bytes and the pause machine.
  tag_t        ring_tag [NUM_CLASS][FIFO_DEPTH];
  len_t        ring_len [NUM_CLASS][FIFO_DEPTH];
  int          rd_idx [NUM_CLASS];
  int          wr_idx [NUM_CLASS];
  int          occupancy [NUM_CLASS];
  bytes_t      queued_bytes [NUM_CLASS];
  send_state_t link_state;
  class_t      serving;
  logic        busy;

  result_t     expected_events [$];
  int          errors;
  int          checked;
  int          drops;

  initial begin
    errors  = 0;
    checked = 0;
    drops   = 0;
  end

  task automatic flag_error(input string msg);
    $display("[%0t] MISMATCH: %s", $time, msg);
    errors++;
  endtask

  task automatic compare_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
    if (got !== want)
      flag_error($sformatf("event %0d %s got 0x%0h expected 0x%0h", checked, name, got,
                           want));
  endtask

  function automatic result_t make_event(input event_e kind, input class_t c,
                                         input tag_t t, input len_t l);
    result_t r;
    r            = '0;
    r.event_kind = kind;
    r.out_class  = c;
    r.out_tag    = t;
    r.out_len    = l;
    return r;
  endfunction

  task automatic clear_port();
    for (int c = 0; c < NUM_CLASS; c++) begin
      rd_idx[c]       = 0;
      wr_idx[c]       = 0;
      occupancy[c]    = 0;
      queued_bytes[c] = '0;
    end
    link_state = ST_READY;
    serving    = CLASS_NONE;
    busy       = 1'b0;
    expected_events.delete();
  endtask

  task automatic predict_command(input logic [OP_W-1:0] op, input class_t cls_in,
                                 input len_t len_in, input tag_t tag_in,
                                 input logic [TIME_W-1:0] ptime);
    result_t            batch [$];
    class_t             c;
    len_t               ln;
    int                 h;
    int                 k;
    logic [TOTAL_W-1:0] total;
    c  = (cls_in == CLASS_NONE) ? CLASS_HIGH : cls_in;
    ln = (len_in > LEN_W'(MAX_LEN)) ? LEN_W'(MAX_LEN) : len_in;
    case (op)
      OP_ENQUEUE: begin
        if (occupancy[c] >= FIFO_DEPTH) begin
          batch.push_back(make_event(EV_DROPPED, c, tag_in, ln));
        end else begin
          ring_tag[c][wr_idx[c]] = tag_in;
          ring_len[c][wr_idx[c]] = ln;
          wr_idx[c]              = (wr_idx[c] + 1) % FIFO_DEPTH;
          occupancy[c]++;
          queued_bytes[c]        = queued_bytes[c] + ln;
          batch.push_back(make_event(EV_ENQUEUED, c, tag_in, ln));
        end
      end
      OP_PAUSE: begin
        if (ptime != '0) begin
          if (link_state == ST_READY) begin
            if (busy) link_state = ST_PAUSE_RCVD;
            else link_state = ST_PAUSED;
          end
        end else begin
          link_state = ST_READY;
        end
        batch.push_back(make_event(EV_PAUSE, CLASS_LOW, '0, '0));
      end
      OP_DONE: begin
        if (busy && serving != CLASS_NONE && occupancy[serving] > 0) begin
          h = rd_idx[serving];
          batch.push_back(make_event(EV_DEPARTED, serving, ring_tag[serving][h],
                                     ring_len[serving][h]));
          rd_idx[serving] = (h + 1) % FIFO_DEPTH;
          occupancy[serving]--;
          if (queued_bytes[serving] >= ring_len[serving][h])
            queued_bytes[serving] = queued_bytes[serving] - ring_len[serving][h];
          else
            queued_bytes[serving] = '0;
        end else begin
          batch.push_back(make_event(EV_SPURIOUS, CLASS_LOW, '0, '0));
        end
        busy    = 1'b0;
        serving = CLASS_NONE;
        if (link_state == ST_PAUSE_RCVD) link_state = ST_PAUSED;
      end
      default: return;
    endcase
    // Start the head of the highest non-empty class when ready and idle.
    if (link_state == ST_READY && !busy) begin
      for (k = NUM_CLASS - 1; k >= 0 && !busy; k--) begin
        if (occupancy[k] > 0) begin
          busy    = 1'b1;
          serving = class_t'(k);
          batch.push_back(make_event(EV_STARTED, serving, ring_tag[k][rd_idx[k]],
                                     ring_len[k][rd_idx[k]]));
        end
      end
    end
    total = TOTAL_W'(queued_bytes[0]) + TOTAL_W'(queued_bytes[1]) + TOTAL_W'(queued_bytes[2]);
    foreach (batch[i]) begin
      batch[i].total_bytes = total;
      batch[i].send_state  = link_state;
      batch[i].last        = (i == batch.size() - 1);
      expected_events.push_back(batch[i]);
    end
  endtask

  task automatic check_event();
    result_t want;
    if (expected_events.size() == 0) begin
      flag_error($sformatf("unexpected event kind %0d class %0d tag 0x%0h", evt.event_kind,
                           evt.out_class, evt.out_tag));
    end else begin
      want = expected_events.pop_front();
      compare_field("event_kind", evt.event_kind, want.event_kind);
      compare_field("out_class", evt.out_class, want.out_class);
      compare_field("out_tag", evt.out_tag, want.out_tag);
      compare_field("out_len", evt.out_len, want.out_len);
      compare_field("total_bytes", evt.total_bytes, want.total_bytes);
      compare_field("send_state", evt.send_state, want.send_state);
      compare_field("last", evt.last, want.last);
      if (want.event_kind == EV_DROPPED) drops++;
      checked++;
    end
  endtask

  // Predict before checking so the queue order holds even for same-edge events.
  always @(posedge clk) begin
    if (rst) begin
      clear_port();
    end else begin
      if (cmd.valid && cmd.ready)
        predict_command(cmd.operation, cmd.pkt_class, cmd.pkt_len, cmd.pkt_tag,
                        cmd.pause_time);
      if (evt.valid && evt.ready) check_event();
    end
    pending_events <= expected_events.size();
    fail_count     <= errors;
    events_checked <= checked;
    drops_seen     <= drops;
  end

endmodule

/* tb/tb_strict_priority_pause_queue.sv */
// Testbench top for the strict priority pause queue: clock, reset, command stimulus
// and event back-pressure, with spq_event_checker watching both channels.
// Depends on spq_pkg, spq_if, spq_event_checker and the block itself.
module tb_strict_priority_pause_queue;
  import spq_pkg::*;

  // Operation code three carries no meaning; the block must swallow it silently.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 1300;
  localparam int SETTLE_CYCLES = 20;

  typedef enum int {
    EP_MIXED,
    EP_FLOOD,
    EP_PAUSE_STORM,
    EP_DRAIN
  } episode_e;

  typedef enum int {
    RX_OPEN,
    RX_COIN,
    RX_PERIODIC,
    RX_LONG_STALL
  } rx_mode_e;

  logic clk;
  logic rst;

  spq_cmd_if cmd_ch ();
  spq_evt_if evt_ch ();

  int fail_count;
  int pending_events;
  int events_checked;
  int drops_seen;

  // Sender bookkeeping: items left in the current burst and per-operation counts.
  int burst_left;
  int n_enqueue;
  int n_pause;
  int n_done;
  int n_ignored;
  int random_sent;

  strict_priority_pause_queue i_dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .evt (evt_ch)
  );

  spq_event_checker i_checker (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd_ch),
    .evt            (evt_ch),
    .fail_count     (fail_count),
    .pending_events (pending_events),
    .events_checked (events_checked),
    .drops_seen     (drops_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs or loses events.
  initial begin
    #6000000;
    $display("strict_priority_pause_queue test failed");
    $finish;
  end

  // Pick the next burst: mostly short, sometimes a long stretch with no gaps.
  function automatic int pick_burst();
    if ($urandom_range(0, 3) == 0) return $urandom_range(30, 120);
    return $urandom_range(1, 6);
  endfunction

  // Lengths: mostly frame-sized, with zero, one, the maximum and overlong values mixed in.
  function automatic len_t rand_len();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return len_t'($urandom_range(MAX_LEN + 1, 16383));
      2:       return LEN_W'(MAX_LEN);
      3:       return len_t'(1);
      4, 5:    return len_t'($urandom_range(1, MAX_LEN));
      default: return len_t'($urandom_range(64, 1518));
    endcase
  endfunction

  // Drive one item and hold it until the block takes it; then maybe open a gap.
  task automatic send_cmd(input logic [OP_W-1:0] op, input class_t cls, input len_t len,
                          input tag_t tag, input logic [TIME_W-1:0] ptime);
    cmd_ch.valid      <= 1'b1;
    cmd_ch.operation  <= op;
    cmd_ch.pkt_class  <= cls;
    cmd_ch.pkt_len    <= len;
    cmd_ch.pkt_tag    <= tag;
    cmd_ch.pause_time <= ptime;
    do @(posedge clk); while (!cmd_ch.ready);
    case (op)
      OP_ENQUEUE: n_enqueue++;
      OP_PAUSE:   n_pause++;
      OP_DONE:    n_done++;
      default:    n_ignored++;
    endcase
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      // Drop valid for a random gap, then start a fresh burst.
      cmd_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = pick_burst();
    end
  endtask

  // Hold the sender off until every predicted event has been seen.
  task automatic drain_wait();
    cmd_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_events != 0);
    burst_left = pick_burst();
  endtask

  // One stretch of random traffic with a given mix of operations.
  task automatic run_episode(input episode_e kind, input int n_items);
    int                  p_enq;
    int                  p_pause;
    int                  p_done;
    int                  r;
    class_t              flood_class;
    logic [OP_W-1:0]     op;
    class_t              cls;
    len_t                len;
    tag_t                tag;
    logic [TIME_W-1:0]   pt;
    flood_class = class_t'($urandom_range(0, 2));
    case (kind)
      EP_FLOOD:       begin p_enq = 85; p_pause = 5;  p_done = 6;  end
      EP_PAUSE_STORM: begin p_enq = 35; p_pause = 35; p_done = 25; end
      EP_DRAIN:       begin p_enq = 15; p_pause = 5;  p_done = 77; end
      default:        begin p_enq = 50; p_pause = 10; p_done = 36; end
    endcase
    for (int i = 0; i < n_items; i++) begin
      // Randomize every field, meaningful or not, then shape the ones that matter.
      cls = class_t'($urandom_range(0, 3));
      len = rand_len();
      tag = tag_t'($urandom);
      pt  = TIME_W'($urandom);
      r   = $urandom_range(0, 99);
      if (r < p_enq) begin
        op = OP_ENQUEUE;
        if (kind == EP_FLOOD) begin
          cls = flood_class;
          if (flood_class == CLASS_HIGH && $urandom_range(0, 3) == 0) cls = CLASS_NONE;
        end
      end else if (r < p_enq + p_pause) begin
        op = OP_PAUSE;
        if ($urandom_range(0, 2) == 0) pt = '0;
        else pt = TIME_W'($urandom_range(1, 65535));
      end else if (r < p_enq + p_pause + p_done) begin
        op = OP_DONE;
      end else begin
        op = OP_UNUSED;
      end
      send_cmd(op, cls, len, tag, pt);
      if (op != OP_UNUSED) random_sent++;
    end
  endtask

  // Receiver back-pressure: switch between open, coin-flip, periodic and long stalls.
  initial begin : rx_stall
    rx_mode_e mode;
    int       left;
    int       hold;
    bit       stalled;
    mode    = RX_OPEN;
    left    = 0;
    hold    = 0;
    stalled = 1'b0;
    evt_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (left == 0) begin
        mode = rx_mode_e'($urandom_range(0, 3));
        left = $urandom_range(16, 200);
      end
      left--;
      case (mode)
        RX_OPEN:     evt_ch.ready <= 1'b1;
        RX_COIN:     evt_ch.ready <= 1'($urandom_range(0, 1));
        RX_PERIODIC: evt_ch.ready <= (left % 5) > 1;
        default: begin
          if (hold == 0) begin
            stalled = !stalled;
            hold    = stalled ? $urandom_range(1, 20) : $urandom_range(1, 6);
          end
          hold--;
          evt_ch.ready <= !stalled;
        end
      endcase
    end
  end

  initial begin : stimulus
    episode_e kind;
    rst               = 1'b1;
    cmd_ch.valid      = 1'b0;
    cmd_ch.operation  = OP_ENQUEUE;
    cmd_ch.pkt_class  = CLASS_LOW;
    cmd_ch.pkt_len    = '0;
    cmd_ch.pkt_tag    = '0;
    cmd_ch.pause_time = '0;
    burst_left  = pick_burst();
    n_enqueue   = 0;
    n_pause     = 0;
    n_done      = 0;
    n_ignored   = 0;
    random_sent = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed part: walk the pause machine and the enqueue corner cases.
    send_cmd(OP_DONE, CLASS_LOW, '0, '0, '0);                   // completion, nothing in flight
    send_cmd(OP_PAUSE, CLASS_LOW, '0, '0, '0);                  // resume while already ready
    send_cmd(OP_ENQUEUE, CLASS_LOW, len_t'(1), '0, '0);         // starts at once
    send_cmd(OP_ENQUEUE, CLASS_MID, LEN_W'(MAX_LEN), 16'hFFFF, 16'hFFFF);
    send_cmd(OP_ENQUEUE, CLASS_NONE, 14'h3FFF, 16'h5A5A, '0);   // class three, overlong length
    send_cmd(OP_ENQUEUE, CLASS_HIGH, '0, 16'hA5A5, '0);         // zero length
    send_cmd(OP_PAUSE, CLASS_LOW, '0, '0, 16'hFFFF);            // pause with packet in flight
    send_cmd(OP_PAUSE, CLASS_LOW, '0, '0, 16'd1);               // repeated pause holds state
    send_cmd(OP_DONE, CLASS_LOW, '0, '0, '0);                   // departs, then paused
    send_cmd(OP_PAUSE, CLASS_LOW, '0, '0, 16'h8000);            // pause while paused
    send_cmd(OP_ENQUEUE, CLASS_LOW, 14'd100, 16'h0001, '0);     // no start while paused
    send_cmd(OP_UNUSED, CLASS_NONE, 14'h3FFF, 16'hFFFF, 16'hFFFF);
    send_cmd(OP_PAUSE, CLASS_LOW, '0, '0, '0);                  // resume starts high class
    send_cmd(OP_PAUSE, CLASS_LOW, '0, '0, 16'd7);               // pause with packet in flight
    send_cmd(OP_PAUSE, CLASS_LOW, '0, '0, '0);                  // resume must not restart it
    repeat (5) send_cmd(OP_DONE, CLASS_LOW, '0, '0, '0);        // drain to a spurious done
    send_cmd(OP_PAUSE, CLASS_LOW, '0, '0, 16'd3);               // pause while idle
    send_cmd(OP_DONE, CLASS_LOW, '0, '0, '0);                   // spurious while paused
    send_cmd(OP_ENQUEUE, CLASS_MID, 14'd64, 16'h1234, '0);
    send_cmd(OP_PAUSE, CLASS_LOW, '0, '0, '0);                  // resume starts the mid packet
    send_cmd(OP_DONE, CLASS_LOW, '0, '0, '0);
    drain_wait();

    // Random part: episodes of mixed traffic, floods that fill a class, pause storms
    // and drains; every so often hold off until the event stream is empty.
    while (random_sent < RANDOM_ITEMS) begin
      kind = episode_e'($urandom_range(0, 3));
      run_episode(kind, (kind == EP_FLOOD) ? 90 : $urandom_range(20, 60));
      if ($urandom_range(0, 3) == 0) drain_wait();
    end

    drain_wait();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("run covered %0d enqueues, %0d pause frames, %0d completions, %0d ignored items",
             n_enqueue, n_pause, n_done, n_ignored);
    $display("checked %0d events in order, %0d of them drops on a full class",
             events_checked, drops_seen);
    if (fail_count == 0 && pending_events == 0) begin
      $display("strict_priority_pause_queue test passed");
    end else begin
      $display("strict_priority_pause_queue test failed");
    end
    $finish;
  end

endmodule
